@@ design/tbot_pkg.sv @@
// Package for the triangle/box overlap test: widths, axis codes, config indices, queue size.
`default_nettype none
package tbot_pkg;
    localparam int COORD_W_DEF = 16;
    localparam logic [3:0] AXIS_NONE = 4'd13;
    localparam logic [2:0] CFG_LOW_X  = 3'd0;
    localparam logic [2:0] CFG_LOW_Y  = 3'd1;
    localparam logic [2:0] CFG_LOW_Z  = 3'd2;
    localparam logic [2:0] CFG_HIGH_X = 3'd3;
    localparam logic [2:0] CFG_HIGH_Y = 3'd4;
    localparam logic [2:0] CFG_HIGH_Z = 3'd5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
endpackage
`default_nettype wire

@@ design/tbot_front.sv @@
// Front part: accepts triangles, centers vertices, forms edges and box extents (registered).
`default_nettype none
module tbot_front import tbot_pkg::*; #(
    parameter int CW = COORD_W_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic signed [CW-1:0]   i_v   [9],
    input  wire logic signed [CW-1:0]   i_lo  [3],
    input  wire logic signed [CW-1:0]   i_hi  [3],
    output logic                        o_valid,
    output logic signed [CW+1:0]        o_pt  [9],
    output logic signed [CW:0]          o_half[3],
    output logic signed [CW:0]          o_e   [9]
);
    logic signed [CW+1:0] n_pt [9];
    logic signed [CW:0]   n_half[3];
    logic signed [CW:0]   n_e  [9];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_half[i] = (CW+1)'(i_hi[i]) - (CW+1)'(i_lo[i]);
            for (int k = 0; k < 3; k++)
                n_pt[k*3+i] = ((CW+2)'(i_v[k*3+i]) <<< 1)
                    - ((CW+2)'(i_lo[i]) + (CW+2)'(i_hi[i]));
            n_e[i]   = (CW+1)'(i_v[3+i]) - (CW+1)'(i_v[i]);
            n_e[3+i] = (CW+1)'(i_v[6+i]) - (CW+1)'(i_v[3+i]);
            n_e[6+i] = (CW+1)'(i_v[i])   - (CW+1)'(i_v[6+i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_pt   <= n_pt;
            o_half <= n_half;
            o_e    <= n_e;
        end
    end
endmodule
`default_nettype wire

@@ design/tbot_queue.sv @@
// Short queue between the front and back parts.
`default_nettype none
module tbot_queue import tbot_pkg::*; #(
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_data,
    input  wire logic          i_pop,
    output logic               o_empty,
    output logic               o_room2,
    output logic [DW-1:0]      o_data
);
    logic [DW-1:0]   r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_room2 = (r_cnt <= (QPTR_W+1)'(QUEUE_DEPTH - 2));
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

@@ design/tbot_axis.sv @@
// One separating-axis test, two pipeline stages (products, then sums/compares).
`default_nettype none
module tbot_axis import tbot_pkg::*; #(
    parameter int CW = COORD_W_DEF,
    parameter int AW = 2*CW+3
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [CW+1:0] i_pt  [9],
    input  wire logic signed [CW:0]   i_half[3],
    input  wire logic signed [AW-1:0] i_ax  [3],
    output logic                      o_sep
);
    localparam int PW = CW + 2 + AW;
    localparam int SW = PW + 2;
    logic signed [PW-1:0] r_p [9];
    logic signed [PW-1:0] r_t [3];
    logic signed [AW-1:0] abs_ax [3];
    logic signed [SW-1:0] s_r, s_p [3];
    logic above, below;

    always_comb begin
        for (int i = 0; i < 3; i++)
            abs_ax[i] = i_ax[i][AW-1] ? -i_ax[i] : i_ax[i];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_t[i] <= PW'(i_half[i]) * PW'(abs_ax[i]);
                for (int k = 0; k < 3; k++)
                    r_p[k*3+i] <= PW'(i_pt[k*3+i]) * PW'(i_ax[i]);
            end
        end
    end

    always_comb begin
        s_r = SW'(r_t[0]) + SW'(r_t[1]) + SW'(r_t[2]);
        above = 1'b1; below = 1'b1;
        for (int k = 0; k < 3; k++) begin
            s_p[k] = SW'(r_p[k*3]) + SW'(r_p[k*3+1]) + SW'(r_p[k*3+2]);
            if (!(s_p[k] > s_r))  above = 1'b0;
            if (!(-s_r > s_p[k])) below = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_sep <= above | below;
    end
endmodule
`default_nettype wire

@@ design/tbot_back.sv @@
// Back part: normal product stage, then thirteen parallel axis tests and priority pick.
`default_nettype none
module tbot_back import tbot_pkg::*; #(
    parameter int CW = COORD_W_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_valid,
    input  wire logic signed [CW+1:0] i_pt  [9],
    input  wire logic signed [CW:0]   i_half[3],
    input  wire logic signed [CW:0]   i_e   [9],
    output logic                      o_valid,
    output logic [3:0]                o_axis
);
    localparam int AW = 2*CW + 3;
    // stage 1: normal partial products
    logic signed [2*CW+1:0] r_m [6];
    logic signed [CW+1:0]   r_pt [9];
    logic signed [CW:0]     r_half[3];
    logic signed [CW:0]     r_e [9];
    logic [2:0]             r_vld;
    logic signed [AW-1:0]   ax [13][3];
    logic [12:0]            sep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
        if (i_en) begin
            r_m[0] <= i_e[1] * i_e[5]; r_m[1] <= i_e[2] * i_e[4];
            r_m[2] <= i_e[2] * i_e[3]; r_m[3] <= i_e[0] * i_e[5];
            r_m[4] <= i_e[0] * i_e[4]; r_m[5] <= i_e[1] * i_e[3];
            r_pt <= i_pt; r_half <= i_half; r_e <= i_e;
        end
    end

    always_comb begin
        for (int a = 0; a < 13; a++)
            for (int i = 0; i < 3; i++) ax[a][i] = '0;
        for (int i = 0; i < 3; i++) ax[i][i] = AW'(1);
        ax[3][0] = AW'(r_m[0]) - AW'(r_m[1]);
        ax[3][1] = AW'(r_m[2]) - AW'(r_m[3]);
        ax[3][2] = AW'(r_m[4]) - AW'(r_m[5]);
        for (int j = 0; j < 3; j++) begin
            ax[4+j][1]  = -AW'(r_e[j*3+2]); ax[4+j][2]  =  AW'(r_e[j*3+1]);
            ax[7+j][0]  =  AW'(r_e[j*3+2]); ax[7+j][2]  = -AW'(r_e[j*3]);
            ax[10+j][0] = -AW'(r_e[j*3+1]); ax[10+j][1] =  AW'(r_e[j*3]);
        end
    end

    for (genvar a = 0; a < 13; a++) begin : g_ax
        tbot_axis #(.CW(CW), .AW(AW)) u_axis (
            .i_clk(i_clk), .i_en(i_en), .i_pt(r_pt), .i_half(r_half),
            .i_ax(ax[a]), .o_sep(sep[a])
        );
    end

    always_comb begin
        o_axis = AXIS_NONE;
        for (int a = 12; a >= 0; a--)
            if (sep[a]) o_axis = 4'(a);
    end
    assign o_valid = r_vld[2];
endmodule
`default_nettype wire

@@ design/triangle_box_overlap_test.sv @@
// Top level: triangle versus axis-aligned box separating-axis overlap test.
// Throughput: one triangle per cycle when the output is not stalled.
// Path from input accept to result valid: front register, queue write, normal
// products, axis products, axis compares, output register, plus queue wait under stall.
// Synchronous active-low reset clears all valid flags and the box to zero.
`default_nettype none
module triangle_box_overlap_test import tbot_pkg::*; #(
    parameter int COORD_WIDTH = COORD_W_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_vert0_x, i_vert0_y, i_vert0_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_vert1_x, i_vert1_y, i_vert1_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_vert2_x, i_vert2_y, i_vert2_z,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic signed [COORD_WIDTH-1:0] i_cfg_data,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_overlaps,
    output logic [3:0]                         o_separating_axis
);
    localparam int CW = COORD_WIDTH;
    localparam int QW = 9*(CW+2) + 3*(CW+1) + 9*(CW+1);

    logic signed [CW-1:0] r_lo [3], r_hi [3];
    logic signed [CW-1:0] v [9];
    logic f_valid;
    logic signed [CW+1:0] f_pt [9], b_pt [9];
    logic signed [CW:0]   f_half [3], b_half [3], f_e [9], b_e [9];
    logic q_empty, q_room2, q_pop, b_valid, back_en;
    logic [QW-1:0] q_in, q_out;
    logic [3:0] b_axis;
    logic r_ovalid;
    logic [3:0] r_axis;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_lo[i] <= '0; r_hi[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOW_X:  r_lo[0] <= i_cfg_data;
                CFG_LOW_Y:  r_lo[1] <= i_cfg_data;
                CFG_LOW_Z:  r_lo[2] <= i_cfg_data;
                CFG_HIGH_X: r_hi[0] <= i_cfg_data;
                CFG_HIGH_Y: r_hi[1] <= i_cfg_data;
                CFG_HIGH_Z: r_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign v = '{i_vert0_x, i_vert0_y, i_vert0_z, i_vert1_x, i_vert1_y, i_vert1_z,
                 i_vert2_x, i_vert2_y, i_vert2_z};

    // queue keeps room for the item already in the front register
    assign o_stall = !q_room2;

    tbot_front #(.CW(CW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(1'b1),
        .i_valid(i_valid && q_room2), .i_v(v), .i_lo(r_lo), .i_hi(r_hi),
        .o_valid(f_valid), .o_pt(f_pt), .o_half(f_half), .o_e(f_e)
    );

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            q_in[i*(CW+2) +: CW+2] = f_pt[i];
            q_in[9*(CW+2) + 3*(CW+1) + i*(CW+1) +: CW+1] = f_e[i];
            b_pt[i] = q_out[i*(CW+2) +: CW+2];
            b_e[i]  = q_out[9*(CW+2) + 3*(CW+1) + i*(CW+1) +: CW+1];
        end
        for (int i = 0; i < 3; i++) begin
            q_in[9*(CW+2) + i*(CW+1) +: CW+1] = f_half[i];
            b_half[i] = q_out[9*(CW+2) + i*(CW+1) +: CW+1];
        end
    end

    tbot_queue #(.DW(QW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(f_valid), .i_data(q_in),
        .i_pop(q_pop), .o_empty(q_empty), .o_room2(q_room2), .o_data(q_out)
    );

    // back pipeline advances whenever the output register can take its result, or when no valid result leaves it
    assign back_en = !(r_ovalid && i_stall) || !b_valid;
    assign q_pop   = back_en && !q_empty;

    tbot_back #(.CW(CW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(back_en), .i_valid(q_pop),
        .i_pt(b_pt), .i_half(b_half), .i_e(b_e),
        .o_valid(b_valid), .o_axis(b_axis)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (!(r_ovalid && i_stall)) begin
            r_ovalid <= b_valid;
        end
        if (!(r_ovalid && i_stall)) r_axis <= b_axis;
    end

    assign o_valid           = r_ovalid;
    assign o_separating_axis = r_axis;
    assign o_overlaps        = (r_axis == AXIS_NONE);
endmodule
`default_nettype wire
